@@ rtl/tec_pkg.sv @@
// Shared widths, event codes, register indexes and reset values for the touch
// event and calibration block. No dependencies; compiled first.
`default_nettype none

package tec_pkg;

   // Field widths
   localparam int RAW_BITS   = 12;
   localparam int COORD_BITS = 10;
   localparam int GAIN_BITS  = 16;
   localparam int FRAC_BITS  = 16;
   localparam int EVENT_BITS = 2;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = GAIN_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISPLAY_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISPLAY_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAW_CENTER_X   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAW_CENTER_Y   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_RAW_X     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_RAW_Y     = 3'd5;

   // Register reset values
   localparam logic [COORD_BITS-1:0] RST_DISPLAY_WIDTH  = COORD_BITS'(240);
   localparam logic [COORD_BITS-1:0] RST_DISPLAY_HEIGHT = COORD_BITS'(320);
   localparam logic [RAW_BITS-1:0]   RST_RAW_CENTER_X   = RAW_BITS'(2160);
   localparam logic [RAW_BITS-1:0]   RST_RAW_CENTER_Y   = RAW_BITS'(2100);
   localparam logic [GAIN_BITS-1:0]  RST_GAIN_RAW_X     = GAIN_BITS'(5774);
   localparam logic [GAIN_BITS-1:0]  RST_GAIN_RAW_Y     = GAIN_BITS'(4397);

   // Touch tracker states, also the event codes on the response
   localparam logic [EVENT_BITS-1:0] EV_NONE = 2'd0;
   localparam logic [EVENT_BITS-1:0] EV_DOWN = 2'd1;
   localparam logic [EVENT_BITS-1:0] EV_HOLD = 2'd2;
   localparam logic [EVENT_BITS-1:0] EV_UP   = 2'd3;

endpackage : tec_pkg

`default_nettype wire

@@ rtl/tec_if.sv @@
// Request and response channel interfaces of the touch event block.
// Depends on tec_pkg for field widths.
`default_nettype none

interface tec_req_if import tec_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                pen_down;
   logic                sample_valid;
   logic [RAW_BITS-1:0] raw_x;
   logic [RAW_BITS-1:0] raw_y;

   modport source (output valid, pen_down, sample_valid, raw_x, raw_y, input ready);
   modport sink   (input valid, pen_down, sample_valid, raw_x, raw_y, output ready);
endinterface : tec_req_if

interface tec_rsp_if import tec_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [EVENT_BITS-1:0] touch_event;
   logic [COORD_BITS-1:0] point_x;
   logic [COORD_BITS-1:0] point_y;

   modport source (output valid, touch_event, point_x, point_y, input ready);
   modport sink   (input valid, touch_event, point_x, point_y, output ready);
endinterface : tec_rsp_if

`default_nettype wire

@@ rtl/touch_event_and_calibration.sv @@
// Top level of the touch event tracker with raw-to-screen calibration.
// Depends on tec_pkg and the channel interfaces in tec_if.sv.
//
// One request (a sensor poll) gives one response: the touch event (none,
// down, hold, up) and the screen point. A request is taken into an input
// register; from there the two axis multipliers, the range checks and the
// tracker update run and load the tracker state and last point (the response
// register) once that register is empty or being read. A request can be
// accepted every cycle while the response side keeps taking results. The
// tracker state and last point feed the next request, so requests are
// processed in order, one per cycle while responses are taken. Calibration
// registers are to be written by the user through the csr_ port only while
// no request is in flight; the block itself does not enforce this.
`default_nettype none

module touch_event_and_calibration import tec_pkg::*; (
   input  wire                       clock,
   input  wire                       reset,
   tec_req_if.sink                   req_if,
   tec_rsp_if.source                 rsp_if,
   input  wire                       csr_wr_en,
   input  wire [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire [CSR_DATA_BITS-1:0]   csr_wr_data
);

   localparam int DIFF_W = RAW_BITS + 1;
   localparam int PROD_W = DIFF_W + GAIN_BITS + 1;
   localparam int SUM_W  = PROD_W + 1;
   localparam int QUO_W  = SUM_W - FRAC_BITS;
   localparam int HALF_W = COORD_BITS - 1;

   typedef struct packed {
      logic                  ok;
      logic [COORD_BITS-1:0] value;
   } axis_type;

   // Scale one axis: trunc(diff * gain / 2^16 + half), checked against 0..bound
   function automatic axis_type map_axis(
      input logic signed [DIFF_W-1:0] diff,
      input logic [GAIN_BITS-1:0]     gain,
      input logic [HALF_W-1:0]        half,
      input logic [COORD_BITS-1:0]    bound
   );
      logic signed [PROD_W-1:0] prod;
      logic signed [SUM_W-1:0]  sum;
      logic        [QUO_W-1:0]  quo;
      axis_type                 res;
      prod = PROD_W'(diff) * PROD_W'($signed({1'b0, gain}));
      sum  = SUM_W'(prod) + $signed(SUM_W'({half, {FRAC_BITS{1'b0}}}));
      quo  = sum[SUM_W-1:FRAC_BITS];
      res.value = quo[COORD_BITS-1:0];
      res.ok    = 1'b0;
      if (!sum[SUM_W-1]) begin
         res.ok = (quo[QUO_W-2:0] <= (QUO_W-1)'(bound));
      end else if ((&quo) && (sum[FRAC_BITS-1:0] != '0)) begin
         // a sum just below zero truncates to zero
         res.ok    = 1'b1;
         res.value = '0;
      end
      return res;
   endfunction

   // Calibration registers
   logic [COORD_BITS-1:0] display_width_ff, display_height_ff;
   logic [RAW_BITS-1:0]   raw_center_x_ff, raw_center_y_ff;
   logic [GAIN_BITS-1:0]  gain_raw_x_ff, gain_raw_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         display_width_ff  <= RST_DISPLAY_WIDTH;
         display_height_ff <= RST_DISPLAY_HEIGHT;
         raw_center_x_ff   <= RST_RAW_CENTER_X;
         raw_center_y_ff   <= RST_RAW_CENTER_Y;
         gain_raw_x_ff     <= RST_GAIN_RAW_X;
         gain_raw_y_ff     <= RST_GAIN_RAW_Y;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DISPLAY_WIDTH:  display_width_ff  <= csr_wr_data[COORD_BITS-1:0];
            CSR_DISPLAY_HEIGHT: display_height_ff <= csr_wr_data[COORD_BITS-1:0];
            CSR_RAW_CENTER_X:   raw_center_x_ff   <= csr_wr_data[RAW_BITS-1:0];
            CSR_RAW_CENTER_Y:   raw_center_y_ff   <= csr_wr_data[RAW_BITS-1:0];
            CSR_GAIN_RAW_X:     gain_raw_x_ff     <= csr_wr_data[GAIN_BITS-1:0];
            CSR_GAIN_RAW_Y:     gain_raw_y_ff     <= csr_wr_data[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Handshake control
   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic advance, load, req_take;

   assign advance      = !out_valid_ff || rsp_if.ready;
   assign load         = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || load;
   assign req_take     = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register
   logic                pen_down_ff, sample_valid_ff;
   logic [RAW_BITS-1:0] raw_x_ff, raw_y_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         pen_down_ff     <= req_if.pen_down;
         sample_valid_ff <= req_if.sample_valid;
         raw_x_ff        <= req_if.raw_x;
         raw_y_ff        <= req_if.raw_y;
      end
   end

   // Tracker state and last point; these also form the response register
   logic [EVENT_BITS-1:0] touch_state_ff, touch_state_in;
   logic [COORD_BITS-1:0] last_x_ff, last_x_in;
   logic [COORD_BITS-1:0] last_y_ff, last_y_in;

   // Axis selection: portrait swaps the axes and flips the raw X direction
   logic                     portrait;
   logic signed [DIFF_W-1:0] diff_x, diff_y, diff_x_neg;
   logic signed [DIFF_W-1:0] x_diff, y_diff;
   logic [GAIN_BITS-1:0]     x_gain, y_gain;
   axis_type                 x_map, y_map;

   assign portrait   = display_width_ff < display_height_ff;
   assign diff_x     = $signed({1'b0, raw_x_ff}) - $signed({1'b0, raw_center_x_ff});
   assign diff_x_neg = $signed({1'b0, raw_center_x_ff}) - $signed({1'b0, raw_x_ff});
   assign diff_y     = $signed({1'b0, raw_y_ff}) - $signed({1'b0, raw_center_y_ff});

   assign x_diff = portrait ? diff_y : diff_x;
   assign x_gain = portrait ? gain_raw_y_ff : gain_raw_x_ff;
   assign y_diff = portrait ? diff_x_neg : diff_y;
   assign y_gain = portrait ? gain_raw_x_ff : gain_raw_y_ff;

   assign x_map = map_axis(x_diff, x_gain, display_width_ff[COORD_BITS-1:1],
                           display_width_ff);
   assign y_map = map_axis(y_diff, y_gain, display_height_ff[COORD_BITS-1:1],
                           display_height_ff);

   // Event and point update
   logic [EVENT_BITS-1:0] next_event;
   logic                  map_en;

   always_comb begin
      if (pen_down_ff) begin
         next_event = (touch_state_ff == EV_NONE || touch_state_ff == EV_UP)
                    ? EV_DOWN : EV_HOLD;
      end else begin
         next_event = (touch_state_ff == EV_DOWN || touch_state_ff == EV_HOLD)
                    ? EV_UP : EV_NONE;
      end
      map_en = (next_event == EV_DOWN || next_event == EV_HOLD) && sample_valid_ff;

      last_x_in = (map_en && x_map.ok) ? x_map.value : last_x_ff;
      last_y_in = (map_en && y_map.ok) ? y_map.value : last_y_ff;

      // a press that lands on the last point reports nothing
      touch_state_in = next_event;
      if (next_event == EV_DOWN && last_x_in == last_x_ff && last_y_in == last_y_ff) begin
         touch_state_in = EV_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touch_state_ff <= EV_NONE;
         last_x_ff      <= '0;
         last_y_ff      <= '0;
      end else if (load) begin
         touch_state_ff <= touch_state_in;
         last_x_ff      <= last_x_in;
         last_y_ff      <= last_y_in;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.touch_event = touch_state_ff;
   assign rsp_if.point_x     = last_x_ff;
   assign rsp_if.point_y     = last_y_ff;

   // Checks
   a_down_moves_point: assert property (@(posedge clock) disable iff (reset)
      (load && touch_state_in == EV_DOWN) |=>
         (last_x_ff != $past(last_x_ff) || last_y_ff != $past(last_y_ff)))
      else $error("down event reported on the previous point");

   a_idle_events_hold_point: assert property (@(posedge clock) disable iff (reset)
      (load && (touch_state_in == EV_NONE || touch_state_in == EV_UP)) |=>
         ($stable(last_x_ff) && $stable(last_y_ff)))
      else $error("point changed on a none or up event");

   a_hold_follows_press: assert property (@(posedge clock) disable iff (reset)
      (load && touch_state_in == EV_HOLD) |=>
         ($past(touch_state_ff) == EV_DOWN || $past(touch_state_ff) == EV_HOLD))
      else $error("hold event without a preceding press");

   a_empty_output_takes_request: assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff && in_valid_ff) |=> out_valid_ff)
      else $error("pending request not moved to an empty response register");

endmodule : touch_event_and_calibration

`default_nettype wire

@@ tb/sv/tb_touch_event_and_calibration.sv @@
// Self-checking testbench for the touch event tracker with calibration.
// Needs tec_pkg and the channel interfaces in tec_if.sv; drives polls, checks
// each response against a built-in tracker and mapping predictor.
`default_nettype none

module tb_touch_event_and_calibration;
   import tec_pkg::*;

   localparam int CLK_PERIOD       = 20;
   localparam int TIMEOUT_CYCLES   = 1000000;
   localparam int SETTLE_CYCLES    = 4;
   localparam int NUM_PHASES       = 8;
   localparam int PHASE_POLLS      = 235;
   localparam int LONG_HOLD_AT     = 400;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int RAW_MAX          = (1 << RAW_BITS) - 1;

   // Indexes past the register list; writes there must be ignored
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic                pen_down;
      logic                sample_valid;
      logic [RAW_BITS-1:0] raw_x;
      logic [RAW_BITS-1:0] raw_y;
   } touch_poll_type;

   typedef struct packed {
      logic [EVENT_BITS-1:0] touch_event;
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
   } touch_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Request side drive registers, and the response side ready
   logic                poll_valid  = 1'b0;
   logic                poll_pen    = 1'b0;
   logic                poll_sample = 1'b0;
   logic [RAW_BITS-1:0] poll_rx     = '0;
   logic [RAW_BITS-1:0] poll_ry     = '0;
   logic                report_ready = 1'b0;

   logic                      csr_wr_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data = '0;

   tec_req_if req_bus ();
   tec_rsp_if rsp_bus ();

   assign req_bus.valid        = poll_valid;
   assign req_bus.pen_down     = poll_pen;
   assign req_bus.sample_valid = poll_sample;
   assign req_bus.raw_x        = poll_rx;
   assign req_bus.raw_y        = poll_ry;
   assign rsp_bus.ready        = report_ready;

   touch_event_and_calibration u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Calibration mirror
   logic [COORD_BITS-1:0] cal_width  = RST_DISPLAY_WIDTH;
   logic [COORD_BITS-1:0] cal_height = RST_DISPLAY_HEIGHT;
   logic [RAW_BITS-1:0]   ctr_x      = RST_RAW_CENTER_X;
   logic [RAW_BITS-1:0]   ctr_y      = RST_RAW_CENTER_Y;
   logic [GAIN_BITS-1:0]  gain_x     = RST_GAIN_RAW_X;
   logic [GAIN_BITS-1:0]  gain_y     = RST_GAIN_RAW_Y;

   // Tracker mirror
   logic [EVENT_BITS-1:0] tracker = EV_NONE;
   logic [COORD_BITS-1:0] held_x  = '0;
   logic [COORD_BITS-1:0] held_y  = '0;

   touch_poll_type   poll_q[$];
   touch_report_type report_q[$];
   int unsigned      polls_queued = 0;
   int unsigned      reports_seen = 0;
   int unsigned      mismatches   = 0;

   // Last raw spot of a stroke, reused so a new press can land on it
   logic [RAW_BITS-1:0] stroke_x = '0;
   logic [RAW_BITS-1:0] stroke_y = '0;

   // Raw offset scaled by a Q0.16 gain plus half the screen, cut toward zero
   function automatic longint scale_axis(longint diff, longint gain, longint half);
      return (diff * gain + (half << FRAC_BITS)) / (longint'(1) << FRAC_BITS);
   endfunction

   // Advance the tracker mirror by one poll and give the expected report
   function automatic touch_report_type predict_touch_report(touch_poll_type p);
      touch_report_type rep;
      logic [EVENT_BITS-1:0] ev;
      logic [COORD_BITS-1:0] px, py;
      longint rx, ry, cx, cy, dx, dy, sx, sy, wlim, hlim;
      px = held_x;
      py = held_y;
      if (p.pen_down)
         ev = (tracker == EV_NONE || tracker == EV_UP) ? EV_DOWN : EV_HOLD;
      else
         ev = (tracker == EV_DOWN || tracker == EV_HOLD) ? EV_UP : EV_NONE;
      if ((ev == EV_DOWN || ev == EV_HOLD) && p.sample_valid) begin
         rx = longint'(p.raw_x);
         ry = longint'(p.raw_y);
         cx = longint'(ctr_x);
         cy = longint'(ctr_y);
         wlim = longint'(cal_width);
         hlim = longint'(cal_height);
         dx = rx - cx;
         dy = ry - cy;
         if (cal_width < cal_height) begin
            // portrait: axes swapped, x mirrored
            sx = scale_axis(dy, longint'(gain_y), wlim >> 1);
            sy = scale_axis(-dx, longint'(gain_x), hlim >> 1);
         end else begin
            sx = scale_axis(dx, longint'(gain_x), wlim >> 1);
            sy = scale_axis(dy, longint'(gain_y), hlim >> 1);
         end
         // out-of-range axis keeps its last value
         if (sx >= 0 && sx <= wlim) px = sx[COORD_BITS-1:0];
         if (sy >= 0 && sy <= hlim) py = sy[COORD_BITS-1:0];
      end
      // a press that lands on the last point is dropped
      if (ev == EV_DOWN && px == held_x && py == held_y) ev = EV_NONE;
      tracker = ev;
      held_x = px;
      held_y = py;
      rep.touch_event = ev;
      rep.point_x = px;
      rep.point_y = py;
      return rep;
   endfunction

   // Idle length: mostly none or short, a few long, and calm stretches
   function automatic int unsigned draw_idle(inout int unsigned calm_left);
      int unsigned r;
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Raw reading: anywhere on the panel, or close to a given spot
   function automatic logic [RAW_BITS-1:0] pick_raw(logic [RAW_BITS-1:0] around);
      int unsigned r;
      int span, v;
      r = $urandom_range(0, 99);
      if (r < 25) return RAW_BITS'($urandom_range(0, RAW_MAX));
      span = (r < 65) ? 64 : 1023;
      v = int'(around) + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) v = 0;
      if (v > RAW_MAX) v = RAW_MAX;
      return RAW_BITS'(v);
   endfunction

   task automatic queue_poll(input logic pen, input logic sample,
                             input logic [RAW_BITS-1:0] rx, input logic [RAW_BITS-1:0] ry);
      touch_poll_type p;
      p.pen_down = pen;
      p.sample_valid = sample;
      p.raw_x = rx;
      p.raw_y = ry;
      poll_q.push_back(p);
      polls_queued++;
   endtask

   // One press-hold-release stroke, or a lone noise poll
   task automatic queue_stroke();
      int unsigned presses, lifts;
      logic [RAW_BITS-1:0] rx, ry;
      if ($urandom_range(0, 99) < 12) begin
         queue_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    RAW_BITS'($urandom_range(0, RAW_MAX)),
                    RAW_BITS'($urandom_range(0, RAW_MAX)));
         return;
      end
      presses = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      lifts = $urandom_range(1, 3);
      if ($urandom_range(0, 4) != 0) begin
         rx = pick_raw(ctr_x);
         ry = pick_raw(ctr_y);
      end else begin
         rx = stroke_x;
         ry = stroke_y;
      end
      repeat (presses) begin
         queue_poll(1'b1, $urandom_range(0, 7) != 0, rx, ry);
         stroke_x = rx;
         stroke_y = ry;
         if ($urandom_range(0, 1) != 0) begin
            rx = pick_raw(rx);
            ry = pick_raw(ry);
         end
      end
      repeat (lifts)
         queue_poll(1'b0, 1'($urandom_range(0, 1)),
                    RAW_BITS'($urandom_range(0, RAW_MAX)),
                    RAW_BITS'($urandom_range(0, RAW_MAX)));
   endtask

   // Register write; the mirror takes the value masked to the register
   task automatic write_cal_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                                input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         CSR_DISPLAY_WIDTH:  cal_width  = data[COORD_BITS-1:0];
         CSR_DISPLAY_HEIGHT: cal_height = data[COORD_BITS-1:0];
         CSR_RAW_CENTER_X:   ctr_x      = data[RAW_BITS-1:0];
         CSR_RAW_CENTER_Y:   ctr_y      = data[RAW_BITS-1:0];
         CSR_GAIN_RAW_X:     gain_x     = data[GAIN_BITS-1:0];
         CSR_GAIN_RAW_Y:     gain_y     = data[GAIN_BITS-1:0];
         default: ;
      endcase
   endtask

   // Full calibration; junk in the unused upper data bits, plus a spare index
   task automatic program_calibration(input logic [COORD_BITS-1:0] w,
                                      input logic [COORD_BITS-1:0] h,
                                      input logic [RAW_BITS-1:0] cx,
                                      input logic [RAW_BITS-1:0] cy,
                                      input logic [GAIN_BITS-1:0] gx,
                                      input logic [GAIN_BITS-1:0] gy);
      write_cal_reg(CSR_DISPLAY_WIDTH,  {6'($urandom_range(0, 63)), w});
      write_cal_reg(CSR_DISPLAY_HEIGHT, {6'($urandom_range(0, 63)), h});
      write_cal_reg(CSR_RAW_CENTER_X,   {4'($urandom_range(0, 15)), cx});
      write_cal_reg(CSR_RAW_CENTER_Y,   {4'($urandom_range(0, 15)), cy});
      write_cal_reg(CSR_GAIN_RAW_X, gx);
      write_cal_reg(CSR_GAIN_RAW_Y, gy);
      write_cal_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                    CSR_DATA_BITS'($urandom));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Wait for every queued request to be answered, then let the pipe settle
   task automatic wait_drained();
      while (reports_seen != polls_queued) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Request driver: records the prediction when a request is taken
   always @(posedge clock) begin : poll_driver
      int unsigned tx_wait, tx_calm;
      touch_poll_type cur;
      if (reset) begin
         poll_valid <= 1'b0;
         tx_wait = 0;
         tx_calm = 0;
      end else begin
         if (poll_valid && req_bus.ready) begin
            cur.pen_down = poll_pen;
            cur.sample_valid = poll_sample;
            cur.raw_x = poll_rx;
            cur.raw_y = poll_ry;
            report_q.push_back(predict_touch_report(cur));
         end
         if (!poll_valid || req_bus.ready) begin
            if (tx_wait != 0) begin
               tx_wait--;
               poll_valid <= 1'b0;
            end else if (poll_q.size() != 0) begin
               cur = poll_q.pop_front();
               poll_pen    <= cur.pen_down;
               poll_sample <= cur.sample_valid;
               poll_rx     <= cur.raw_x;
               poll_ry     <= cur.raw_y;
               poll_valid  <= 1'b1;
               tx_wait = draw_idle(tx_calm);
            end else begin
               poll_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and checker, with random back-pressure
   always @(posedge clock) begin : report_monitor
      int unsigned rx_wait, rx_calm;
      bit long_hold_done;
      touch_report_type want;
      if (reset) begin
         report_ready <= 1'b0;
         rx_wait = 0;
         rx_calm = 0;
         long_hold_done = 1'b0;
      end else begin
         if (rsp_bus.valid && report_ready) begin
            reports_seen++;
            if (report_q.size() == 0) begin
               $error("response with no request outstanding: event %0d point (%0d,%0d)",
                      rsp_bus.touch_event, rsp_bus.point_x, rsp_bus.point_y);
               mismatches++;
            end else begin
               want = report_q.pop_front();
               if (rsp_bus.touch_event !== want.touch_event) begin
                  $error("touch_event: expected %0d, got %0d",
                         want.touch_event, rsp_bus.touch_event);
                  mismatches++;
               end
               if (rsp_bus.point_x !== want.point_x) begin
                  $error("point_x: expected %0d, got %0d", want.point_x, rsp_bus.point_x);
                  mismatches++;
               end
               if (rsp_bus.point_y !== want.point_y) begin
                  $error("point_y: expected %0d, got %0d", want.point_y, rsp_bus.point_y);
                  mismatches++;
               end
            end
         end
         // one long hold-off so the block backs up into the request side
         if (!long_hold_done && reports_seen >= LONG_HOLD_AT) begin
            rx_wait = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (rx_wait != 0) begin
            rx_wait--;
            report_ready <= 1'b0;
         end else begin
            report_ready <= 1'b1;
            rx_wait = draw_idle(rx_calm);
         end
      end
   end

   // Stimulus sequence
   initial begin : stimulus
      int unsigned target;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed polls, reset calibration (portrait 240x320)
      queue_poll(1'b0, 1'b0, 12'd0, 12'd0);          // idle stays none
      queue_poll(1'b1, 1'b1, 12'd2160, 12'd2100);    // press at the center
      queue_poll(1'b1, 1'b1, 12'd0, 12'd0);          // both axes out of range
      queue_poll(1'b1, 1'b1, 12'd4095, 12'd4095);    // both out, other side
      queue_poll(1'b1, 1'b0, 12'd4095, 12'd0);       // failed sample holds point
      queue_poll(1'b1, 1'b1, 12'd2160, 12'd310);     // x just below zero cuts to 0
      queue_poll(1'b0, 1'b1, 12'd4095, 12'd4095);    // release
      queue_poll(1'b0, 1'b0, 12'd0, 12'd0);          // back to none
      queue_poll(1'b1, 1'b0, 12'd1234, 12'd2345);    // press, failed sample: on last point
      queue_poll(1'b1, 1'b1, 12'd2160, 12'd310);     // press mapping to the last point
      queue_poll(1'b1, 1'b1, 12'd1000, 12'd3000);    // real press
      queue_poll(1'b1, 1'b1, 12'd1000, 12'd3000);    // hold in place
      queue_poll(1'b0, 1'b0, 12'd2048, 12'd2048);    // release
      queue_poll(1'b1, 1'b1, 12'd1000, 12'd3000);    // re-press on same spot
      queue_poll(1'b1, 1'b1, 12'd2160, 12'd2100);    // press elsewhere
      queue_poll(1'b0, 1'b1, 12'd1365, 12'd2730);    // release
      queue_poll(1'b0, 1'b1, 12'd2730, 12'd1365);    // none
      queue_poll(1'b1, 1'b1, 12'd1000, 12'd0);       // press, only x out of range
      queue_poll(1'b1, 1'b1, 12'd4095, 12'd2100);    // hold, only y out of range
      queue_poll(1'b0, 1'b0, 12'd4095, 12'd4095);    // release
      wait_drained();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: program_calibration(COORD_BITS'($urandom_range(1, 1023)),
                                   COORD_BITS'($urandom_range(1, 1023)),
                                   RAW_BITS'($urandom_range(0, RAW_MAX)),
                                   RAW_BITS'($urandom_range(0, RAW_MAX)),
                                   GAIN_BITS'($urandom_range(0, 65535)),
                                   GAIN_BITS'($urandom_range(0, 65535)));
            1: program_calibration(10'd1, 10'd1, 12'd0, 12'd0, 16'd0, 16'd0);
            2: program_calibration(10'd1023, 10'd1023, 12'd4095, 12'd4095,
                                   16'hFFFF, 16'hFFFF);
            3: program_calibration(10'd1, 10'd1023, 12'd2048, 12'd2048,
                                   16'hFFFF, 16'hFFFF);
            4: program_calibration(10'd1023, 10'd1, RAW_BITS'($urandom_range(0, RAW_MAX)),
                                   RAW_BITS'($urandom_range(0, RAW_MAX)),
                                   GAIN_BITS'($urandom_range(0, 65535)),
                                   GAIN_BITS'($urandom_range(0, 65535)));
            5: program_calibration(10'd320, 10'd240, 12'd2160, 12'd2100,
                                   16'd5774, 16'd4397);
            6: program_calibration(10'd240, 10'd320, 12'd2160, 12'd2100,
                                   16'd5774, 16'd4397);
            default: program_calibration(COORD_BITS'($urandom_range(1, 1023)),
                                         COORD_BITS'($urandom_range(1, 1023)),
                                         RAW_BITS'($urandom_range(0, RAW_MAX)),
                                         RAW_BITS'($urandom_range(0, RAW_MAX)),
                                         GAIN_BITS'($urandom_range(0, 4095)),
                                         GAIN_BITS'($urandom_range(0, 4095)));
         endcase
         target = polls_queued + PHASE_POLLS;
         while (polls_queued < target) queue_stroke();
         wait_drained();
      end

      if (report_q.size() != 0) begin
         $error("%0d expected responses never arrived", report_q.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule : tb_touch_event_and_calibration

`default_nettype wire
